// ===== hdl/l4hx_pkg.sv =====
package l4hx_pkg;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	localparam int unsigned ETH_HDR_LEN = 14;
	localparam int unsigned IP_MIN_END  = 34;
	localparam int unsigned TCP_HDR_LEN = 20;
	localparam int unsigned UDP_HDR_LEN = 8;

	// byte positions of the captured header fields
	localparam int unsigned POS_ETYPE_HI = 12;
	localparam int unsigned POS_ETYPE_LO = 13;
	localparam int unsigned POS_IHL      = 14;
	localparam int unsigned POS_PROTO    = 23;
	localparam int unsigned POS_SRC_LO   = 26;
	localparam int unsigned POS_SRC_HI   = 29;
	localparam int unsigned POS_DST_LO   = 30;
	localparam int unsigned POS_DST_HI   = 33;

	// transport offset 14 + IHL*4 stays below 2^7
	localparam int unsigned TOFF_BITS = 7;

	localparam logic [1:0] KIND_TCP   = 2'd0;
	localparam logic [1:0] KIND_UDP   = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} l4hx_in_t;

	typedef struct packed {
		logic        accepted;
		logic [31:0] src_address;
		logic [31:0] dst_address;
		logic [1:0]  transport_kind;
		logic [15:0] src_port_out;
		logic [15:0] dst_port_out;
		logic [15:0] frame_length;
	} l4hx_out_t;

	// header fields as they stand after the current beat
	typedef struct packed {
		logic [15:0] ether_kind;
		logic [3:0]  header_words;
		logic [7:0]  proto_number;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
	} l4hx_fields_t;

endpackage

// ===== hdl/l4hx_capture.sv =====
module l4hx_capture
	import l4hx_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       beat_en,
	input  l4hx_in_t                   beat,
	output l4hx_fields_t               fields,
	output logic [LENGTH_BITS-1:0]     len,
	output logic [TOFF_BITS-1:0]       t_off
);

	logic [LENGTH_BITS-1:0] pos_q;
	l4hx_fields_t           fields_q;
	logic [LENGTH_BITS-1:0] t_w;
	logic [7:0]             d;

	assign d = beat.data_byte;

	always_comb begin
		fields = fields_q;
		if (pos_q == LENGTH_BITS'(POS_ETYPE_HI) || pos_q == LENGTH_BITS'(POS_ETYPE_LO)) begin
			fields.ether_kind = {fields_q.ether_kind[7:0], d};
		end
		if (pos_q == LENGTH_BITS'(POS_IHL)) begin
			fields.header_words = d[3:0];
		end
		if (pos_q == LENGTH_BITS'(POS_PROTO)) begin
			fields.proto_number = d;
		end
		if (pos_q >= LENGTH_BITS'(POS_SRC_LO) && pos_q <= LENGTH_BITS'(POS_SRC_HI)) begin
			fields.src_addr = {fields_q.src_addr[23:0], d};
		end
		if (pos_q >= LENGTH_BITS'(POS_DST_LO) && pos_q <= LENGTH_BITS'(POS_DST_HI)) begin
			fields.dst_addr = {fields_q.dst_addr[23:0], d};
		end
		// offset follows the IHL of this very beat when it is byte 14
		t_off = TOFF_BITS'(ETH_HDR_LEN) + {1'b0, fields.header_words, 2'b00};
		t_w   = LENGTH_BITS'(t_off);
		if (pos_q == t_w || pos_q == t_w + LENGTH_BITS'(1)) begin
			fields.sport = {fields_q.sport[7:0], d};
		end
		if (pos_q == t_w + LENGTH_BITS'(2) || pos_q == t_w + LENGTH_BITS'(3)) begin
			fields.dport = {fields_q.dport[7:0], d};
		end
		// saturate the byte count
		len = (&pos_q) ? pos_q : pos_q + LENGTH_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			fields_q <= '0;
		end else if (beat_en) begin
			if (beat.last_byte) begin
				pos_q    <= '0;
				fields_q <= '0;
			end else begin
				pos_q    <= len;
				fields_q <= fields;
			end
		end
	end

endmodule

// ===== hdl/l4hx_check.sv =====
module l4hx_check
	import l4hx_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  l4hx_fields_t               fields,
	input  logic [LENGTH_BITS-1:0]     len,
	input  logic [TOFF_BITS-1:0]       t_off,
	output l4hx_out_t                  result
);

	localparam int unsigned LW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

	logic [TOFF_BITS:0] tcp_end;
	logic [TOFF_BITS:0] udp_end;
	logic [LW-1:0]      len_w;
	logic               ok;
	logic [1:0]         kind;

	always_comb begin
		tcp_end = {1'b0, t_off} + (TOFF_BITS + 1)'(TCP_HDR_LEN);
		udp_end = {1'b0, t_off} + (TOFF_BITS + 1)'(UDP_HDR_LEN);
		len_w   = LW'(len);
		ok      = (len >= LENGTH_BITS'(IP_MIN_END)) && (fields.ether_kind == ETHERTYPE_IPV4);
		if (fields.proto_number == PROTO_TCP) begin
			kind = KIND_TCP;
			if (len < LENGTH_BITS'(tcp_end)) begin
				ok = 1'b0;
			end
		end else if (fields.proto_number == PROTO_UDP) begin
			kind = KIND_UDP;
			if (len < LENGTH_BITS'(udp_end)) begin
				ok = 1'b0;
			end
		end else begin
			kind = KIND_OTHER;
		end

		result = '0;
		if (ok) begin
			result.accepted       = 1'b1;
			result.src_address    = fields.src_addr;
			result.dst_address    = fields.dst_addr;
			result.transport_kind = kind;
			if (kind != KIND_OTHER) begin
				result.src_port_out = fields.sport;
				result.dst_port_out = fields.dport;
			end
			result.frame_length = (len_w > LW'(16'hFFFF)) ? 16'hFFFF : len_w[15:0];
		end
	end

endmodule

// ===== hdl/ipv4_l4_header_extractor_core.sv =====
// Channel   Direction  Handshake                   Payload
// frame     in         frame_valid / frame_ready   frame_data  (l4hx_in_t, one byte a beat)
// result    out        result_valid / result_ready result_data (l4hx_out_t, one per frame)
//
// One byte a cycle while no last beat waits; a byte is registered, then parsed.
// A result is registered when the last beat of its frame leaves the input register.
// Reset clears the byte count, all captured fields and both valid flags.
// Only a last beat waits on a full, unread result register; all other beats flow
// through while a result is waiting.
module ipv4_l4_header_extractor_core
	import l4hx_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      frame_valid,
	output logic      frame_ready,
	input  l4hx_in_t  frame_data,
	output logic      result_valid,
	input  logic      result_ready,
	output l4hx_out_t result_data
);

	logic                   valid_s1;
	l4hx_in_t               beat_s1;
	logic                   result_valid_q;
	l4hx_out_t              result_q;
	logic                   load_ok;
	logic                   adv;
	l4hx_fields_t           fields;
	logic [LENGTH_BITS-1:0] len;
	logic [TOFF_BITS-1:0]   t_off;
	l4hx_out_t              verdict;

	assign load_ok     = !result_valid_q || result_ready;
	// hold a last beat while the result register is still occupied
	assign adv         = valid_s1 && (!beat_s1.last_byte || load_ok);
	assign frame_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_ready) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_ready && frame_valid) begin
			beat_s1 <= frame_data;
		end
	end

	l4hx_capture #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_capture (
		.clk    (clk),
		.arst_n (arst_n),
		.beat_en(adv),
		.beat   (beat_s1),
		.fields (fields),
		.len    (len),
		.t_off  (t_off)
	);

	l4hx_check #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_check (
		.fields(fields),
		.len   (len),
		.t_off (t_off),
		.result(verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && beat_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && beat_s1.last_byte) begin
			result_q <= verdict;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && beat_s1.last_byte && result_valid_q && !result_ready |-> !frame_ready)
		else $error("last beat advanced over an unread result");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> frame_ready)
		else $error("empty input stage refused a beat");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.accepted |->
			result_q.frame_length == 16'd0 && result_q.src_address == 32'd0 &&
			result_q.dst_address == 32'd0 && result_q.transport_kind == KIND_TCP)
		else $error("rejected frame carries nonzero fields");

	a_other_no_ports: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.transport_kind == KIND_OTHER |->
			result_q.src_port_out == 16'd0 && result_q.dst_port_out == 16'd0)
		else $error("unknown protocol carries ports");

	a_accept_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.accepted |-> result_q.frame_length >= 16'(IP_MIN_END))
		else $error("accepted frame shorter than header");

endmodule
